// ===== design/dwg_pkg.sv =====
package dwg_pkg;

    localparam int GRID_N_DEF = 64;
    localparam int COEF_Q16   = 32113;

    localparam logic [1:0] ACT_MASK = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [15:0]         pos_x;
        logic [15:0]         pos_z;
        logic signed [31:0]  mask_value;
        logic [15:0]         damping;
        logic signed [7:0]   shift_new_x;
        logic signed [7:0]   shift_new_z;
        logic signed [7:0]   shift_old_x;
        logic signed [7:0]   shift_old_z;
    } t_req;

    typedef struct packed {
        logic signed [31:0]  height;
        logic                out_of_zone;
    } t_rsp;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_sts;

endpackage

// ===== design/dwg_ram.sv =====
module dwg_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dwg_engine.sv =====
module dwg_engine #(
    parameter int GRID_N = dwg_pkg::GRID_N_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_enable,
    input  logic               i_start,
    input  dwg_pkg::t_req      i_req,
    input  logic               i_out_free,
    output dwg_pkg::t_rsp      o_rsp,
    output dwg_pkg::t_eng_sts  o_sts
);
    import dwg_pkg::*;

    localparam int AW = $clog2(GRID_N);
    localparam int CW = 2 * AW;
    localparam int GA = CW + 2;
    localparam int SW = ((AW > 8) ? AW : 8) + 2;
    localparam logic [3:0]         PH_LAST    = 4'd11;
    localparam logic [3:0]         PH_RD_LAST = 4'd6;
    localparam logic [AW-1:0]      N_MAX      = AW'(GRID_N - 1);
    localparam logic [15:0]        LIM        = 16'((GRID_N - 1) << 8);
    localparam logic signed [16:0] C_COEF     = 17'(COEF_Q16);
    localparam logic signed [SW-1:0] C_N      = SW'(GRID_N);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_STEP, S_READ, S_DONE} t_state;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] res;
        if (v > 48'sh0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            res = -32'sh8000_0000;
        end else begin
            res = 32'(v);
        end
        return res;
    endfunction

    t_state                 r_state;
    logic [3:0]             r_ph;
    logic [AW-1:0]          r_x, r_z;
    logic [CW:0]            r_clr;
    logic [1:0]             r_cur, r_prev, r_free;
    t_req                   r_req;
    t_rsp                   r_rsp;
    logic                   r_zv;
    logic signed [31:0]     r_c, r_m, r_p, r_nv;
    logic signed [34:0]     r_sum;
    logic signed [35:0]     r_lap;
    logic signed [51:0]     r_a, r_b;
    logic signed [36:0]     r_t;
    logic signed [53:0]     r_prod;
    logic [17:0]            r_wgt;
    logic signed [49:0]     r_mul;
    logic signed [51:0]     r_acc;

    // grid and mask ports
    logic              g_we;
    logic [GA-1:0]     g_waddr, g_raddr;
    logic [31:0]       g_wdata, g_rdata;
    logic              m_we;
    logic [CW-1:0]     m_waddr;
    logic [31:0]       m_wdata, m_rdata;
    logic signed [31:0] grid_rd;

    // sample coordinates for the current phase
    logic signed [SW-1:0] k, l, sx, sz;
    logic [1:0]           sbank;
    logic                 s_ok;
    logic [AW-1:0]        x0, z0, x1, z1;
    logic [8:0]           fx, fz, gx, gz;
    logic                 border, mask_hit;

    dwg_ram #(.ADDR_W(GA), .DATA_W(32)) u_grid (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    dwg_ram #(.ADDR_W(CW), .DATA_W(32)) u_mask (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr ({r_z, r_x}),
        .o_rdata (m_rdata)
    );

    assign grid_rd = r_zv ? $signed(g_rdata) : 32'sd0;

    assign k = SW'($signed({1'b0, r_x})) - SW'(r_req.shift_new_x);
    assign l = SW'($signed({1'b0, r_z})) - SW'(r_req.shift_new_z);

    always_comb begin
        sbank = r_cur;
        unique case (r_ph)
            4'd1: begin
                sx = k - SW'(1);
                sz = l;
            end
            4'd2: begin
                sx = k + SW'(1);
                sz = l;
            end
            4'd3: begin
                sx = k;
                sz = l - SW'(1);
            end
            4'd4: begin
                sx = k;
                sz = l + SW'(1);
            end
            4'd5: begin
                sx    = SW'($signed({1'b0, r_x})) - SW'(r_req.shift_old_x);
                sz    = SW'($signed({1'b0, r_z})) - SW'(r_req.shift_old_z);
                sbank = r_prev;
            end
            default: begin
                sx = k;
                sz = l;
            end
        endcase
        s_ok = (sx >= 0) && (sx < C_N) && (sz >= 0) && (sz < C_N);
    end

    assign x0 = r_req.pos_x[AW+7:8];
    assign z0 = r_req.pos_z[AW+7:8];
    assign x1 = (x0 == N_MAX) ? x0 : x0 + AW'(1);
    assign z1 = (z0 == N_MAX) ? z0 : z0 + AW'(1);
    assign fx = {1'b0, r_req.pos_x[7:0]};
    assign fz = {1'b0, r_req.pos_z[7:0]};
    assign gx = 9'd256 - fx;
    assign gz = 9'd256 - fz;

    assign border = (r_x == '0) || (r_x == N_MAX) || (r_z == '0) || (r_z == N_MAX);
    assign mask_hit = ({1'b0, i_req.pos_x[15:8]} < 9'(GRID_N))
                   && ({1'b0, i_req.pos_z[15:8]} < 9'(GRID_N));

    // grid read address
    always_comb begin
        g_raddr = '0;
        if (r_state == S_STEP) begin
            g_raddr = {sbank, sz[AW-1:0], sx[AW-1:0]};
        end else if (r_state == S_READ) begin
            unique case (r_ph)
                4'd0:    g_raddr = {r_cur, z0, x0};
                4'd1:    g_raddr = {r_cur, z0, x1};
                4'd2:    g_raddr = {r_cur, z1, x0};
                default: g_raddr = {r_cur, z1, x1};
            endcase
        end
    end

    // grid and mask writes
    always_comb begin
        g_we    = 1'b0;
        g_waddr = {1'b0, r_clr};
        g_wdata = '0;
        m_we    = 1'b0;
        m_waddr = r_clr[CW-1:0];
        m_wdata = '0;
        priority if (r_state == S_CLR) begin
            g_we = 1'b1;
            m_we = !r_clr[CW];
        end else if (r_state == S_STEP && r_ph == PH_LAST) begin
            g_we    = 1'b1;
            g_waddr = {r_free, r_z, r_x};
            g_wdata = sat32(48'(r_nv) + 48'(r_m));
            m_we    = 1'b1;
            m_waddr = {r_z, r_x};
        end else if (r_state == S_IDLE && i_start && i_enable
                     && i_req.action == ACT_MASK && mask_hit) begin
            m_we    = 1'b1;
            m_waddr = {i_req.pos_z[AW+7:8], i_req.pos_x[AW+7:8]};
            m_wdata = i_req.mask_value;
        end else begin
            g_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ph    <= '0;
            r_x     <= '0;
            r_z     <= '0;
            r_cur   <= 2'd0;
            r_prev  <= 2'd1;
            r_free  <= 2'd2;
            r_zv    <= 1'b0;
        end else begin
            r_zv <= (r_state == S_STEP) ? s_ok : 1'b1;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + (CW+1)'(1);
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_req             <= i_req;
                        r_rsp.height      <= '0;
                        r_rsp.out_of_zone <= i_enable && (i_req.action == ACT_READ)
                                             && (i_req.pos_x > LIM || i_req.pos_z > LIM);
                        r_ph  <= '0;
                        r_x   <= '0;
                        r_z   <= '0;
                        r_acc <= '0;
                        if (!i_enable) begin
                            r_state <= S_DONE;
                        end else if (i_req.action == ACT_STEP) begin
                            r_state <= S_STEP;
                        end else if (i_req.action == ACT_READ) begin
                            if (i_req.pos_x > LIM || i_req.pos_z > LIM) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_READ;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_STEP: begin
                    unique case (r_ph)
                        4'd1: begin
                            r_c <= grid_rd;
                            r_m <= $signed(m_rdata);
                        end
                        4'd2: r_sum <= 35'(grid_rd);
                        4'd3, 4'd4, 4'd5: r_sum <= r_sum + 35'(grid_rd);
                        4'd6: begin
                            r_p   <= grid_rd;
                            r_lap <= 36'(r_sum) - (36'(r_c) <<< 2);
                        end
                        4'd7: begin
                            r_a <= r_lap * C_COEF;
                            r_b <= (52'(r_c) <<< 17) - (52'(r_p) <<< 16);
                        end
                        4'd8: r_t <= 37'((r_a + r_b + 52'sd32768) >>> 16);
                        4'd9: r_prod <= r_t * $signed({1'b0, r_req.damping});
                        4'd10: begin
                            r_nv <= border ? 32'sd0
                                   : sat32(48'((r_prod + 54'sd32768) >>> 16));
                        end
                        default: begin
                        end
                    endcase
                    if (r_ph == PH_LAST) begin
                        r_ph <= '0;
                        if (r_x == N_MAX) begin
                            r_x <= '0;
                            if (r_z == N_MAX) begin
                                r_cur   <= r_free;
                                r_prev  <= r_cur;
                                r_free  <= r_prev;
                                r_state <= S_DONE;
                            end else begin
                                r_z <= r_z + AW'(1);
                            end
                        end else begin
                            r_x <= r_x + AW'(1);
                        end
                    end else begin
                        r_ph <= r_ph + 4'd1;
                    end
                end
                S_READ: begin
                    unique case (r_ph)
                        4'd0:    r_wgt <= 18'(gx) * 18'(gz);
                        4'd1:    r_wgt <= 18'(fx) * 18'(gz);
                        4'd2:    r_wgt <= 18'(gx) * 18'(fz);
                        4'd3:    r_wgt <= 18'(fx) * 18'(fz);
                        default: r_wgt <= r_wgt;
                    endcase
                    if (r_ph >= 4'd1 && r_ph <= 4'd4) begin
                        r_mul <= grid_rd * $signed(r_wgt);
                    end
                    if (r_ph >= 4'd2 && r_ph <= 4'd5) begin
                        r_acc <= r_acc + 52'(r_mul);
                    end
                    if (r_ph == PH_RD_LAST) begin
                        r_rsp.height <= sat32(48'((r_acc + 52'sd32768) >>> 16));
                        r_state      <= S_DONE;
                    end else begin
                        r_ph <= r_ph + 4'd1;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp      = r_rsp;
    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = (r_state == S_DONE) && i_out_free;

`ifndef SYNTH
    a_bank_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur != r_prev) && (r_cur != r_free) && (r_prev != r_free))
        else $error("grid bank roles overlap");

    a_step_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_ph <= PH_LAST))
        else $error("step phase out of range");

    a_flag_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sts.done && o_rsp.out_of_zone) |-> (r_req.action == ACT_READ))
        else $error("zone flag on a non-read request");

    a_rotate_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_cur != $past(r_cur)) |-> 1'b0)
        else $error("banks rotated in the middle of a step");
`endif

endmodule

// ===== design/damped_wave_grid_step_unit.sv =====
// throughput: one request at a time; the step sweep is bound by the single grid
//   memory read port, six reads per cell
// reset: synchronous active low; a clearing pass zeroes the current, previous and
//   mask grids, requests stall until it ends
module damped_wave_grid_step_unit #(
    parameter int GRID_N = dwg_pkg::GRID_N_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dwg_pkg::t_req i_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output dwg_pkg::t_rsp o_rsp
);
    import dwg_pkg::*;

    // enable register, to be written by the user only while the unit is quiet; the block does not enforce it
    logic     r_enable;
    // output holding register parts the engine from the downstream stall
    logic     r_out_valid;
    t_rsp     r_out;
    t_rsp     eng_rsp;
    t_eng_sts eng_sts;
    logic     out_free;
    logic     start;

    assign out_free = !r_out_valid || !i_out_stall;
    // a new request is taken whenever the engine sits idle
    assign start    = i_in_valid && eng_sts.idle;

    dwg_engine #(.GRID_N(GRID_N)) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_enable   (r_enable),
        .i_start    (start),
        .i_req      (i_req),
        .i_out_free (out_free),
        .o_rsp      (eng_rsp),
        .o_sts      (eng_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_data;
            end
            // engine only finishes when the holding register is free
            if (eng_sts.done) begin
                r_out_valid <= 1'b1;
                r_out       <= eng_rsp;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = !eng_sts.idle;
    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dwg_pkg::*;

    localparam int N      = GRID_N_DEF;
    localparam int CELLS  = N * N;
    localparam int COEF   = COEF_Q16;
    // cap on grid steps
    localparam int MAX_STEPS = 14;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_cfg_we = 1'b0;
    logic   i_cfg_data = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    t_req   i_req = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    t_rsp   o_rsp;

    damped_wave_grid_step_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (i_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_rsp)
    );

    // shadow copy of the wave state
    int     wave_height[CELLS];
    int     wave_prev[CELLS];
    int     wave_inject[CELLS];
    bit     wave_on;
    t_rsp   pending_rsp[$];
    int     error_count;
    int     steps_sent;
    int     idle_pct;
    int     stall_pct;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // generous fixed limit; steps dominate
    initial begin
        #100ms;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom % 100) < stall_pct;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rnd16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint cell_at(bit use_prev, int i, int j);
        if (i < 0 || i >= N || j < 0 || j >= N) return 0;
        return use_prev ? longint'(wave_prev[j * N + i]) : longint'(wave_height[j * N + i]);
    endfunction

    task automatic advance_wave(t_req r);
        int     nxt[CELLS];
        int     k, l;
        longint c, lap, p, t;
        for (int q = 0; q < CELLS; q++) nxt[q] = 0;
        for (int j = 1; j < N - 1; j++) begin
            for (int i = 1; i < N - 1; i++) begin
                k = i - int'(r.shift_new_x);
                l = j - int'(r.shift_new_z);
                c = cell_at(0, k, l);
                lap = cell_at(0, k - 1, l) + cell_at(0, k + 1, l)
                    + cell_at(0, k, l - 1) + cell_at(0, k, l + 1) - 4 * c;
                p = cell_at(1, i - int'(r.shift_old_x), j - int'(r.shift_old_z));
                t = rnd16(longint'(COEF) * lap + (2 * c - p) * 65536);
                nxt[j * N + i] = int'(sat32(rnd16(t * longint'({48'd0, r.damping}))));
            end
        end
        for (int q = 0; q < CELLS; q++) begin
            wave_prev[q] = wave_height[q];
            wave_height[q] = int'(sat32(longint'(nxt[q]) + longint'(wave_inject[q])));
            wave_inject[q] = 0;
        end
    endtask

    function automatic t_rsp sample_height(t_req r);
        t_rsp   rsp;
        int     x0, z0, x1, z1, fx, fz;
        longint acc;
        rsp = '0;
        if (r.pos_x > ((N - 1) << 8) || r.pos_z > ((N - 1) << 8)) begin
            rsp.out_of_zone = 1'b1;
            return rsp;
        end
        x0 = r.pos_x >> 8;   z0 = r.pos_z >> 8;
        fx = r.pos_x & 8'hFF; fz = r.pos_z & 8'hFF;
        x1 = (x0 + 1 < N) ? x0 + 1 : N - 1;
        z1 = (z0 + 1 < N) ? z0 + 1 : N - 1;
        acc = longint'(wave_height[z0 * N + x0]) * ((256 - fx) * (256 - fz))
            + longint'(wave_height[z0 * N + x1]) * (fx * (256 - fz))
            + longint'(wave_height[z1 * N + x0]) * ((256 - fx) * fz)
            + longint'(wave_height[z1 * N + x1]) * (fx * fz);
        rsp.height = 32'(sat32(rnd16(acc)));
        return rsp;
    endfunction

    // predict the response of one accepted request
    task automatic predict_request(t_req r);
        t_rsp rsp;
        rsp = '0;
        if (wave_on) begin
            case (r.action)
                ACT_MASK: begin
                    if ((r.pos_x >> 8) < N && (r.pos_z >> 8) < N)
                        wave_inject[(r.pos_z >> 8) * N + (r.pos_x >> 8)] = r.mask_value;
                end
                ACT_STEP: advance_wave(r);
                ACT_READ: rsp = sample_height(r);
                default: ;
            endcase
        end
        pending_rsp.push_back(rsp);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // response checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response", 1, 0);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.height !== want.height)
                    report_mismatch("height", o_rsp.height, want.height);
                if (o_rsp.out_of_zone !== want.out_of_zone)
                    report_mismatch("out_of_zone", o_rsp.out_of_zone, want.out_of_zone);
            end
        end
    end

    // send one request, called at a rising edge, returns at its acceptance edge
    task automatic send_request(t_req r);
        if (($urandom % 100) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(r);
        if (r.action == ACT_STEP) steps_sent++;
    endtask

    task automatic drain_responses();
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_enable(bit v);
        drain_responses();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        wave_on = v;
        @(posedge i_clk);
    endtask

    function automatic t_req make_req(logic [1:0] act, logic [15:0] px, logic [15:0] pz,
                                      logic [31:0] mv, logic [15:0] dmp,
                                      logic [7:0] snx, logic [7:0] snz,
                                      logic [7:0] sox, logic [7:0] soz);
        t_req r;
        r.action = act; r.pos_x = px; r.pos_z = pz; r.mask_value = mv;
        r.damping = dmp; r.shift_new_x = snx; r.shift_new_z = snz;
        r.shift_old_x = sox; r.shift_old_z = soz;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int   pick;
        r = '0;
        r.mask_value = $urandom;
        r.damping = 16'($urandom);
        pick = $urandom % 100;
        // occasional steps; the rest mask writes, reads and the unused action
        if (pick < 8 && steps_sent < MAX_STEPS) r.action = ACT_STEP;
        else if (pick < 50) r.action = ACT_MASK;
        else if (pick < 95) r.action = ACT_READ;
        else r.action = ACT_NONE;
        if (($urandom % 8) == 0) begin
            r.pos_x = 16'($urandom); r.pos_z = 16'($urandom);
        end else begin
            r.pos_x = 16'($urandom_range(0, (N - 1) << 8));
            r.pos_z = 16'($urandom_range(0, (N - 1) << 8));
        end
        if (($urandom % 6) == 0) begin
            r.shift_new_x = 8'($urandom); r.shift_new_z = 8'($urandom);
            r.shift_old_x = 8'($urandom); r.shift_old_z = 8'($urandom);
        end else begin
            r.shift_new_x = 8'($urandom_range(0, 6) - 3);
            r.shift_new_z = 8'($urandom_range(0, 6) - 3);
            r.shift_old_x = 8'($urandom_range(0, 6) - 3);
            r.shift_old_z = 8'($urandom_range(0, 6) - 3);
        end
        if (($urandom % 5) == 0) r.mask_value = ($urandom % 2) ? 32'h7FFFFFFF : 32'h80000000;
        return r;
    endfunction

    // disabled block: everything gives zero and nothing changes
    task automatic test_disabled();
        send_request(make_req(ACT_MASK, 16'h0505, 16'h0505, 32'h00400000, 16'hFFFF, 0, 0, 0, 0));
        send_request(make_req(ACT_STEP, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'h0500, 16'h0500, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0));
    endtask

    // field extremes, border cells, off-grid mask, shifts, zone edges
    task automatic test_directed();
        send_request(make_req(ACT_MASK, 16'h0000, 16'h0000, 32'h7FFFFFFF, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_MASK, 16'h3FFF, 16'h3FFF, 32'h80000000, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_MASK, 16'h4000, 16'h0A00, 32'h12345678, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_MASK, 16'h0A00, 16'hFFFF, 32'h12345678, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_MASK, 16'h0A80, 16'h0A40, 32'h00010000, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_MASK, 16'h1E00, 16'h1F00, 32'hFFF00000, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_STEP, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'h3F00, 16'h3F00, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'h0A80, 16'h0A40, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'h3E80, 16'h1EC0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'h3F01, 16'h0000, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_STEP, 0, 0, 0, 16'h8000, 8'sd1, -8'sd1, -8'sd2, 8'sd2));
        send_request(make_req(ACT_READ, 16'h0B00, 16'h0A00, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_STEP, 0, 0, 0, 16'h0000, 8'h7F, 8'h80, 8'h80, 8'h7F));
        send_request(make_req(ACT_READ, 16'h0A00, 16'h0A00, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF,
                              8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    task automatic test_random_phase(int count, int idle, int stall);
        drain_responses();
        idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++) send_request(random_req());
    endtask

    // sender holds off until every response is back, then resumes
    task automatic test_sender_pause();
        for (int n = 0; n < 6; n++) send_request(random_req());
        drain_responses();
        for (int n = 0; n < 6; n++) send_request(random_req());
    endtask

    initial begin
        error_count = 0;
        steps_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        wave_on = 1'b0;
        for (int q = 0; q < CELLS; q++) begin
            wave_height[q] = 0; wave_prev[q] = 0; wave_inject[q] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_enable(1'b0);
        test_disabled();
        write_enable(1'b1);
        test_directed();
        test_random_phase(25, 0, 0);
        test_random_phase(25, 62, 0);
        write_enable(1'b0);
        test_random_phase(6, 0, 0);
        write_enable(1'b1);
        test_random_phase(25, 0, 62);
        test_random_phase(25, 25, 25);
        test_sender_pause();

        drain_responses();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
